// ===== hdl/advox_pkg.sv =====
`timescale 1ns / 1ps

package advox_pkg;

    localparam int SAMPLE_W = 12;

    // default shift and tick length
    localparam int BIAS_SHIFT_DEF       = 8;
    localparam int LEVEL_SHIFT_DEF      = 8;
    localparam int SAMPLES_PER_TICK_DEF = 8;

    // reset values of the estimators, before scaling
    localparam int BIAS_MID  = 2048;
    localparam int ENV_INIT  = 1024;

    localparam int SUM_OUT_W   = 16;
    localparam int LEVEL_OUT_W = 16;
    localparam int AUDIO_W     = 24;
    localparam int LINGER_W    = 16;
    localparam int GAIN_W      = 8;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int THRESH_W    = 11;

    localparam logic [MODE_W-1:0]   MODE_RESET   = 2'd0;
    localparam logic [LINGER_W-1:0] LINGER_RESET = 16'd7812;
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 8'd1;

    // vox mode codes
    localparam logic [MODE_W-1:0] VOX_OFF = 2'd0;
    localparam logic [MODE_W-1:0] VOX_LOW = 2'd1;
    localparam logic [MODE_W-1:0] VOX_MID = 2'd2;
    localparam logic [MODE_W-1:0] VOX_TOP = 2'd3;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VOX_MODE = 2'd0,
        REG_LINGER   = 2'd1,
        REG_GAIN     = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [MODE_W-1:0]   vox_mode;
        logic [LINGER_W-1:0] linger_ticks;
        logic [GAIN_W-1:0]   audio_gain;
    } cfg_t;

    typedef struct packed {
        logic signed [SUM_OUT_W-1:0] block_sum;
        logic [LEVEL_OUT_W-1:0]      level;
        logic                        voice_active;
        logic                        tx_enable;
        logic signed [AUDIO_W-1:0]   audio_out;
    } result_t;

    function automatic logic [THRESH_W-1:0] vox_threshold(input logic [MODE_W-1:0] mode);
        logic [THRESH_W-1:0] thr;
        unique case (mode)
            VOX_LOW: thr = 11'd128;
            VOX_MID: thr = 11'd512;
            VOX_TOP: thr = 11'd1024;
            default: thr = 11'd0;
        endcase
        return thr;
    endfunction

endpackage

// ===== hdl/advox_dc_sum.sv =====
`timescale 1ns / 1ps

module advox_dc_sum #(
    parameter int BIAS_SHIFT       = advox_pkg::BIAS_SHIFT_DEF,
    parameter int SAMPLES_PER_TICK = advox_pkg::SAMPLES_PER_TICK_DEF,
    parameter int SUM_W = $clog2(SAMPLES_PER_TICK * (1 << advox_pkg::SAMPLE_W)) + 1
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step,
    input  logic [advox_pkg::SAMPLE_W-1:0]      sample,
    input  logic                                last_of_tick,
    output logic signed [SUM_W-1:0]             tick_sum
);

    localparam int BIAS_W = advox_pkg::SAMPLE_W + BIAS_SHIFT;
    localparam int CNT_W  = $clog2(SAMPLES_PER_TICK + 1);
    localparam int DIFF_W = advox_pkg::SAMPLE_W + 1;

    logic [BIAS_W-1:0]       bias_reg, bias_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    cnt_open;
    logic signed [DIFF_W-1:0] centred;

    // bias += s - bias >> shift, then subtract the updated bias
    assign bias_next = bias_reg + BIAS_W'(sample) - (bias_reg >> BIAS_SHIFT);
    assign centred   = $signed({1'b0, sample})
                     - $signed({1'b0, bias_next[BIAS_W-1:BIAS_SHIFT]});
    assign cnt_open  = cnt_reg < CNT_W'(SAMPLES_PER_TICK);
    assign sum_next  = cnt_open ? sum_reg + SUM_W'(centred) : sum_reg;
    assign tick_sum  = sum_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_reg <= BIAS_W'(advox_pkg::BIAS_MID) << BIAS_SHIFT;
            sum_reg  <= '0;
            cnt_reg  <= '0;
        end else if (step) begin
            bias_reg <= bias_next;
            if (last_of_tick) begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end else begin
                sum_reg <= sum_next;
                if (cnt_open) begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
        end
    end

endmodule

// ===== hdl/advox_vox.sv =====
`timescale 1ns / 1ps

module advox_vox #(
    parameter int LEVEL_SHIFT = advox_pkg::LEVEL_SHIFT_DEF,
    parameter int SUM_W       = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    tick_end,
    input  logic                    ptt,
    input  logic signed [SUM_W-1:0] tick_sum,
    input  advox_pkg::cfg_t         cfg,
    input  logic                    linger_clr,
    output advox_pkg::result_t      result
);

    localparam int MAG_W  = SUM_W - 1;
    localparam int ENV_W  = SUM_W + LEVEL_SHIFT;
    localparam int LVL_W  = ENV_W - LEVEL_SHIFT;
    localparam int SEXT_W = (SUM_W > 17) ? SUM_W : 17;
    localparam int LEXT_W = (LVL_W > 17) ? LVL_W : 17;

    logic [ENV_W-1:0]                    env_reg, env_next;
    logic [advox_pkg::LINGER_W-1:0]      linger_reg, linger_next;
    logic                                tx_reg, voice, tx_next;
    logic signed [SUM_W-1:0]             sum_abs;
    logic [MAG_W-1:0]                    mag;
    logic [LVL_W-1:0]                    lvl;
    logic [LEXT_W-1:0]                   lvl_ext;
    logic signed [SEXT_W-1:0]            sum_ext;
    logic signed [advox_pkg::SUM_OUT_W-1:0] bsum;
    logic signed [advox_pkg::GAIN_W:0]   gain_s;
    logic signed [advox_pkg::AUDIO_W:0]  prod;

    // tick sum saturated to 16 bits
    assign sum_ext = SEXT_W'(tick_sum);
    always_comb begin
        if (sum_ext > SEXT_W'(32767)) begin
            bsum = 16'sh7FFF;
        end else if (sum_ext < SEXT_W'(-32768)) begin
            bsum = -16'sh8000;
        end else begin
            bsum = sum_ext[advox_pkg::SUM_OUT_W-1:0];
        end
    end

    // envelope follows the magnitude
    assign sum_abs  = tick_sum[SUM_W-1] ? -tick_sum : tick_sum;
    assign mag      = sum_abs[MAG_W-1:0];
    assign env_next = env_reg + ENV_W'(mag) - (env_reg >> LEVEL_SHIFT);
    assign lvl      = env_next[ENV_W-1:LEVEL_SHIFT];
    assign lvl_ext  = LEXT_W'(lvl);

    // voice detect with linger countdown, saturating at zero
    always_comb begin
        if (cfg.vox_mode == advox_pkg::VOX_OFF) begin
            linger_next = '0;
            voice       = 1'b0;
        end else if (lvl_ext > LEXT_W'(advox_pkg::vox_threshold(cfg.vox_mode))) begin
            linger_next = cfg.linger_ticks;
            voice       = 1'b1;
        end else begin
            linger_next = (linger_reg != '0) ? linger_reg - 1'b1 : '0;
            voice       = linger_next != '0;
        end
    end

    assign tx_next = voice | ptt;
    assign gain_s  = $signed({1'b0, cfg.audio_gain});
    assign prod    = gain_s * bsum;

    always_comb begin
        result.block_sum    = bsum;
        result.level        = (lvl_ext > LEXT_W'(17'h0FFFF)) ? 16'hFFFF
                                                             : lvl_ext[15:0];
        result.voice_active = voice;
        result.tx_enable    = tx_next;
        result.audio_out    = tx_reg ? prod[advox_pkg::AUDIO_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            env_reg    <= ENV_W'(advox_pkg::ENV_INIT) << LEVEL_SHIFT;
            linger_reg <= '0;
            tx_reg     <= 1'b0;
        end else if (linger_clr) begin
            linger_reg <= '0;
        end else if (tick_end) begin
            env_reg    <= env_next;
            linger_reg <= linger_next;
            tx_reg     <= tx_next;
        end
    end

endmodule

// ===== hdl/audio_dc_level_vox_detector.sv =====
`timescale 1ns / 1ps

// Voice-operated transmit detector for a raw 12-bit microphone sample stream.
// One sample item is taken every cycle unless a held tick end stalls. Each
// item goes into an input register, then through the bias tracker, tick
// accumulator and (on the last sample of a tick) the envelope, vox and gain
// logic combinationally, and the tick's result is held in an output
// register. The bias feedback loop through its register sets the rate of
// one item per cycle. Items that do not end a tick flow on even while a
// result waits; an item that ends a tick waits only while the output register
// is full and not being taken. Registers on the write port: 0 vox mode
// (0 off, 1/2/3 threshold 128/512/1024), 1 linger length in ticks,
// 2 audio gain. Write them only while the block is idle.

module audio_dc_level_vox_detector #(
    parameter int BIAS_SHIFT       = advox_pkg::BIAS_SHIFT_DEF,
    parameter int LEVEL_SHIFT      = advox_pkg::LEVEL_SHIFT_DEF,
    parameter int SAMPLES_PER_TICK = advox_pkg::SAMPLES_PER_TICK_DEF
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    // configuration write port
    input  logic                                        cfg_we,
    input  logic [advox_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  logic [advox_pkg::CFG_DATA_W-1:0]            cfg_wdata,
    // sample input
    input  logic                                        s_valid,
    output logic                                        s_ready,
    input  logic [advox_pkg::SAMPLE_W-1:0]              s_sample,
    input  logic                                        s_last_of_tick,
    input  logic                                        s_ptt,
    // tick results
    output logic                                        m_valid,
    input  logic                                        m_ready,
    output logic signed [advox_pkg::SUM_OUT_W-1:0]      m_block_sum,
    output logic [advox_pkg::LEVEL_OUT_W-1:0]           m_level,
    output logic                                        m_voice_active,
    output logic                                        m_tx_enable,
    output logic signed [advox_pkg::AUDIO_W-1:0]        m_audio_out
);

    localparam int SUM_W = $clog2(SAMPLES_PER_TICK * (1 << advox_pkg::SAMPLE_W)) + 1;

    // configuration registers
    advox_pkg::cfg_t    cfg_reg;
    logic               linger_clr;

    // input register
    logic                             in_valid_reg;
    logic [advox_pkg::SAMPLE_W-1:0]   in_sample_reg;
    logic                             in_last_reg;
    logic                             in_ptt_reg;

    // output register
    logic                  out_valid_reg;
    advox_pkg::result_t    out_reg;

    logic                    step;
    logic                    tick_end;
    logic signed [SUM_W-1:0] tick_sum;
    advox_pkg::result_t      result;

    // a mode write of off also drops the linger count
    assign linger_clr = cfg_we
                     && (advox_pkg::reg_idx_t'(cfg_index) == advox_pkg::REG_VOX_MODE)
                     && (cfg_wdata[advox_pkg::MODE_W-1:0] == advox_pkg::VOX_OFF);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.vox_mode     <= advox_pkg::MODE_RESET;
            cfg_reg.linger_ticks <= advox_pkg::LINGER_RESET;
            cfg_reg.audio_gain   <= advox_pkg::GAIN_RESET;
        end else if (cfg_we) begin
            unique case (advox_pkg::reg_idx_t'(cfg_index))
                advox_pkg::REG_VOX_MODE: begin
                    cfg_reg.vox_mode <= cfg_wdata[advox_pkg::MODE_W-1:0];
                end
                advox_pkg::REG_LINGER: begin
                    cfg_reg.linger_ticks <= cfg_wdata[advox_pkg::LINGER_W-1:0];
                end
                advox_pkg::REG_GAIN: begin
                    cfg_reg.audio_gain <= cfg_wdata[advox_pkg::GAIN_W-1:0];
                end
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    // the held item moves on unless it ends a tick and the result slot is blocked
    assign step     = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign tick_end = step && in_last_reg;
    assign s_ready  = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg <= s_sample;
            in_last_reg   <= s_last_of_tick;
            in_ptt_reg    <= s_ptt;
        end
    end

    advox_dc_sum #(
        .BIAS_SHIFT       (BIAS_SHIFT),
        .SAMPLES_PER_TICK (SAMPLES_PER_TICK),
        .SUM_W            (SUM_W)
    ) u_dc_sum (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .sample       (in_sample_reg),
        .last_of_tick (in_last_reg),
        .tick_sum     (tick_sum)
    );

    advox_vox #(
        .LEVEL_SHIFT (LEVEL_SHIFT),
        .SUM_W       (SUM_W)
    ) u_vox (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick_end   (tick_end),
        .ptt        (in_ptt_reg),
        .tick_sum   (tick_sum),
        .cfg        (cfg_reg),
        .linger_clr (linger_clr),
        .result     (result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (tick_end) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_end) begin
            out_reg <= result;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_block_sum    = out_reg.block_sum;
    assign m_level        = out_reg.level;
    assign m_voice_active = out_reg.voice_active;
    assign m_tx_enable    = out_reg.tx_enable;
    assign m_audio_out    = out_reg.audio_out;

endmodule

// ===== hdl/advox_checker.sv =====
`timescale 1ns / 1ps

module advox_checker (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   s_ready,
    input logic                                   m_valid,
    input logic                                   m_ready,
    input logic signed [advox_pkg::SUM_OUT_W-1:0] m_block_sum,
    input logic [advox_pkg::LEVEL_OUT_W-1:0]      m_level,
    input logic                                   m_voice_active,
    input logic                                   m_tx_enable,
    input logic signed [advox_pkg::AUDIO_W-1:0]   m_audio_out
);

    // a waiting result holds still
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_block_sum) && $stable(m_level)
                                && $stable(m_audio_out) && $stable(m_tx_enable))
        else $error("result changed while stalled");

    // voice activity always keys the transmitter
    a_vox_keys_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_voice_active |-> m_tx_enable)
        else $error("voice active without transmit enable");

    // a silent tick gives silent audio
    a_zero_audio: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_block_sum == '0) |-> (m_audio_out == '0))
        else $error("audio out nonzero for zero tick sum");

    // reset empties both sides
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("handshake not cleared by reset");

endmodule

bind audio_dc_level_vox_detector advox_checker u_checker (.*);
